>>> src/heat_flux_autocorrelation_integrator_assert.svh
`ifndef HEAT_FLUX_AUTOCORRELATION_INTEGRATOR_ASSERT_SVH
`define HEAT_FLUX_AUTOCORRELATION_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HFAI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HFAI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/hfai_pkg.sv
package hfai_pkg;

	localparam int DefMaxSamples = 65536;
	localparam int DefSampleBits = 24;

	localparam int AccW   = 64;
	localparam int AcfW   = 48;
	localparam int IntW   = 64;
	localparam int ScaleW = 32;
	localparam int LagW   = 16;
	localparam int OutW   = LagW + 4 * AcfW + IntW;

	localparam logic [ScaleW-1:0] ScaleReset = 32'd191700000;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_LAG   = 2'd2;

	typedef struct packed {
		logic start;
		logic first_lag;
		logic clear;
	} hfai_merge_cmd_t;

endpackage

>>> src/hfai_lane.sv
module hfai_lane
	import hfai_pkg::*;
#(
	parameter int MAX_SAMPLES = DefMaxSamples,
	parameter int SAMPLE_BITS = DefSampleBits
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    wr_en,
	input  logic [$clog2(MAX_SAMPLES)-1:0]          wr_addr,
	input  logic signed [SAMPLE_BITS-1:0]           wr_data,
	input  logic                                    start,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0]        lag,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0]        len,
	output logic                                    done,
	output logic signed [AcfW-1:0]                  acf
);

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int PW = 2 * SAMPLE_BITS;
	localparam int StepW = $clog2(AccW + 1);

	typedef enum logic [1:0] {L_IDLE, L_SWEEP, L_DRAIN, L_DIV} lane_state_t;

	logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

	lane_state_t               state_q;
	logic [CW-1:0]             n_q, lag_q, len_q, rem_q;
	logic                      v_s1, v_s2;
	logic signed [SAMPLE_BITS-1:0] a_s1, b_s1;
	logic signed [PW-1:0]      prod_s2;
	logic signed [AccW-1:0]    acc_q;
	logic [AccW-1:0]           mag_q;
	logic                      neg_q;
	logic [StepW-1:0]          step_q;
	logic signed [AccW:0]      sum_w;
	logic [CW:0]               rem_sh;
	logic                      ge;
	logic [CW-1:0]             addr_b;

	assign sum_w  = {acc_q[AccW-1], acc_q} + (AccW+1)'(prod_s2);
	assign rem_sh = {rem_q, mag_q[AccW-1]};
	assign ge     = rem_sh >= {1'b0, len_q};
	assign addr_b = n_q + lag_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		a_s1 <= mem[n_q[AW-1:0]];
		b_s1 <= mem[addr_b[AW-1:0]];
		prod_s2 <= PW'(a_s1) * PW'(b_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done    <= 1'b0;
			n_q     <= '0;
			step_q  <= '0;
		end else begin
			done <= 1'b0;
			v_s2 <= v_s1;
			v_s1 <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						lag_q   <= lag;
						len_q   <= len;
						n_q     <= '0;
						acc_q   <= '0;
						state_q <= L_SWEEP;
					end
				end
				L_SWEEP: begin
					if (n_q == len_q) begin
						state_q <= L_DRAIN;
					end else begin
						v_s1 <= 1'b1;
						n_q  <= n_q + 1'b1;
					end
					if (v_s2) begin
						acc_q <= sum_w[AccW-1:0];
					end
				end
				L_DRAIN: begin
					if (v_s2) begin
						if (sum_w[AccW] != sum_w[AccW-1]) begin
							acc_q <= sum_w[AccW] ? {1'b1, {(AccW-1){1'b0}}}
								: {1'b0, {(AccW-1){1'b1}}};
						end else begin
							acc_q <= sum_w[AccW-1:0];
						end
					end else if (!v_s1) begin
						neg_q   <= acc_q[AccW-1];
						mag_q   <= acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= L_DIV;
					end
				end
				L_DIV: begin
					if (step_q == StepW'(AccW)) begin
						if (neg_q) begin
							acf <= (mag_q > (AccW'(1) << (AcfW - 1)))
								? {1'b1, {(AcfW-1){1'b0}}} : AcfW'(-mag_q);
						end else begin
							acf <= (mag_q > AccW'({1'b0, {(AcfW-1){1'b1}}}))
								? {1'b0, {(AcfW-1){1'b1}}} : mag_q[AcfW-1:0];
						end
						done    <= 1'b1;
						state_q <= L_IDLE;
					end else begin
						rem_q  <= ge ? CW'(rem_sh - {1'b0, len_q}) : CW'(rem_sh);
						mag_q  <= {mag_q[AccW-2:0], ge};
						step_q <= step_q + 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
			if (state_q == L_SWEEP && v_s2 && sum_w[AccW] != sum_w[AccW-1]) begin
				acc_q <= sum_w[AccW] ? {1'b1, {(AccW-1){1'b0}}}
					: {1'b0, {(AccW-1){1'b1}}};
			end
		end
	end

endmodule

>>> src/hfai_merge.sv
module hfai_merge
	import hfai_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  hfai_merge_cmd_t        cmd,
	input  logic [ScaleW-1:0]      scale,
	input  logic signed [AcfW-1:0] acf_x,
	input  logic signed [AcfW-1:0] acf_y,
	input  logic signed [AcfW-1:0] acf_z,
	output logic                   done,
	output logic signed [AcfW-1:0] mean,
	output logic signed [IntW-1:0] integral
);

	localparam int SumW = AcfW + 2;
	localparam int DigW = 10;
	localparam int Digits = SumW / DigW;
	localparam int StepW = $clog2(Digits + 1);
	localparam int Recip3 = ((1 << (DigW + 3)) + 2) / 3;
	localparam int TW = AcfW - 32 + ScaleW + 1;

	typedef enum logic [2:0] {M_IDLE, M_DIV, M_MUL, M_ADD, M_ACC} merge_state_t;

	merge_state_t             state_q;
	logic [SumW-1:0]          mag_q;
	logic [1:0]               rem_q;
	logic [StepW-1:0]         step_q;
	logic                     neg_q, first_q;
	logic [63:0]              lo_s1;
	logic [AcfW-32+ScaleW-1:0] hi_s1;
	logic signed [IntW:0]     term_q;
	logic signed [SumW-1:0]   sum_w;
	logic [DigW+1:0]          dig_w;
	logic [2*DigW+3:0]        dprod_w;
	logic [DigW-1:0]          qdig_w;
	logic [1:0]               rdig_w;
	logic [TW-1:0]            t_w, q_w;
	logic signed [IntW:0]     acc_w;

	// The division by three runs one ten-bit digit per cycle, most significant first.
	assign sum_w   = SumW'(acf_x) + SumW'(acf_y) + SumW'(acf_z);
	assign dig_w   = {rem_q, mag_q[SumW-1 -: DigW]};
	assign dprod_w = (2*DigW+4)'(dig_w) * (2*DigW+4)'(Recip3);
	assign qdig_w  = dprod_w[DigW+3 +: DigW];
	assign rdig_w  = 2'(dig_w - (DigW+2)'(qdig_w) - {1'b0, qdig_w, 1'b0});
	assign t_w     = TW'(hi_s1) + TW'(lo_s1[63:32]);
	assign q_w     = first_q ? (t_w >> 17) : (t_w >> 16);
	assign acc_w   = {integral[IntW-1], integral} + term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= M_IDLE;
			done     <= 1'b0;
			integral <= '0;
			step_q   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (cmd.start) begin
						neg_q   <= sum_w[SumW-1];
						mag_q   <= sum_w[SumW-1] ? SumW'(-sum_w) : SumW'(sum_w);
						first_q <= cmd.first_lag;
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= M_DIV;
					end
				end
				M_DIV: begin
					if (step_q == StepW'(Digits)) begin
						mean    <= neg_q ? AcfW'(-mag_q) : mag_q[AcfW-1:0];
						state_q <= M_MUL;
					end else begin
						rem_q  <= rdig_w;
						mag_q  <= {mag_q[SumW-DigW-1:0], qdig_w};
						step_q <= step_q + 1'b1;
					end
				end
				M_MUL: begin
					lo_s1   <= 64'(mag_q[31:0]) * 64'(scale);
					hi_s1   <= (AcfW-32+ScaleW)'(mag_q[AcfW-1:32])
						* (AcfW-32+ScaleW)'(scale);
					state_q <= M_ADD;
				end
				M_ADD: begin
					term_q  <= neg_q ? -(IntW+1)'(q_w) : (IntW+1)'(q_w);
					state_q <= M_ACC;
				end
				M_ACC: begin
					if (acc_w[IntW] != acc_w[IntW-1]) begin
						integral <= acc_w[IntW] ? {1'b1, {(IntW-1){1'b0}}}
							: {1'b0, {(IntW-1){1'b1}}};
					end else begin
						integral <= acc_w[IntW-1:0];
					end
					done    <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
			if (cmd.clear) begin
				integral <= '0;
			end
		end
	end

endmodule

>>> src/heat_flux_autocorrelation_integrator.sv
// Green-Kubo heat-flux integrator. A load request (tuser 1) stores one three-axis
// sample; a clear request (tuser 0) empties the data set and the integral. A lag
// request (tuser 2) with a lag below the sample count (else a status-only result):
// each axis lane sweeps its sample memory once, reading samples n and n + lag
// each cycle into one multiply-accumulate, then runs a 64-step divider; the merge
// stage then divides by three for the mean and updates the integral.
// Requests are not taken while a lag is in progress or its result still waits.
module heat_flux_autocorrelation_integrator
	import hfai_pkg::*;
#(
	parameter int MAX_SAMPLES = DefMaxSamples,
	parameter int SAMPLE_BITS = DefSampleBits
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [ScaleW-1:0]                         cfg_wdata,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// flux_x, flux_y, flux_z
	input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
	// operation
	input  logic [1:0]                                s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// lag_index, acf_x, acf_y, acf_z, acf_mean, conductivity
	output logic [OutW-1:0]                           m_tdata,
	// status
	output logic                                      m_tuser
);

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SB = SAMPLE_BITS;

	typedef enum logic [1:0] {T_IDLE, T_LANES, T_MERGE, T_HOLD} top_state_t;

	top_state_t             state_q;
	logic [ScaleW-1:0]      scale_q;
	logic [CW-1:0]          count_q, lag_q, len_w;
	logic [LagW-1:0]        res_lag_q;
	logic                   res_stat_q;
	logic                   acc_in, wr_en, lane_start, out_free;
	logic [2:0]             lane_done;
	logic signed [AcfW-1:0] acf_x, acf_y, acf_z, mean;
	logic signed [IntW-1:0] integral;
	logic                   merge_done;
	hfai_merge_cmd_t        mcmd;

	assign s_tready   = state_q == T_IDLE;
	assign acc_in     = s_tvalid && s_tready;
	assign wr_en      = acc_in && s_tuser == OP_LOAD && count_q < CW'(MAX_SAMPLES);
	assign lane_start = acc_in && s_tuser == OP_LAG && lag_q < count_q;
	assign len_w      = count_q - lag_q;
	assign out_free   = !m_tvalid || m_tready;

	assign mcmd.start     = state_q == T_LANES && (&lane_done);
	assign mcmd.first_lag = lag_q == '0;
	assign mcmd.clear     = acc_in && s_tuser == OP_CLEAR;

	hfai_lane #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
		.clk, .arst_n, .wr_en, .wr_addr(count_q[AW-1:0]), .wr_data(s_tdata[SB-1:0]),
		.start(lane_start), .lag(lag_q), .len(len_w), .done(lane_done[0]), .acf(acf_x)
	);
	hfai_lane #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
		.clk, .arst_n, .wr_en, .wr_addr(count_q[AW-1:0]),
		.wr_data(s_tdata[2*SB-1:SB]),
		.start(lane_start), .lag(lag_q), .len(len_w), .done(lane_done[1]), .acf(acf_y)
	);
	hfai_lane #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
		.clk, .arst_n, .wr_en, .wr_addr(count_q[AW-1:0]),
		.wr_data(s_tdata[3*SB-1:2*SB]),
		.start(lane_start), .lag(lag_q), .len(len_w), .done(lane_done[2]), .acf(acf_z)
	);

	hfai_merge u_merge (
		.clk, .arst_n, .cmd(mcmd), .scale(scale_q), .acf_x, .acf_y, .acf_z,
		.done(merge_done), .mean, .integral
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			scale_q    <= ScaleReset;
			count_q    <= '0;
			lag_q      <= '0;
			m_tvalid   <= 1'b0;
			res_stat_q <= 1'b0;
			res_lag_q  <= '0;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (m_tvalid && m_tready && state_q != T_HOLD) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (acc_in) begin
						case (s_tuser)
							OP_CLEAR: begin
								count_q <= '0;
								lag_q   <= '0;
							end
							OP_LOAD: begin
								if (wr_en) begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_LAG: begin
								res_lag_q  <= lag_q[LagW-1:0];
								res_stat_q <= !lane_start;
								state_q    <= lane_start ? T_LANES : T_HOLD;
							end
							default: ;
						endcase
					end
				end
				T_LANES: begin
					if (&lane_done) begin
						state_q <= T_MERGE;
					end
				end
				T_MERGE: begin
					if (merge_done) begin
						lag_q   <= lag_q + 1'b1;
						state_q <= T_HOLD;
					end
				end
				T_HOLD: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tuser  <= res_stat_q;
						m_tdata  <= res_stat_q
							? {integral, {(4*AcfW){1'b0}}, res_lag_q}
							: {integral, mean, acf_z, acf_y, acf_x, res_lag_q};
						state_q  <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

endmodule

>>> src/hfai_checker.sv
`include "heat_flux_autocorrelation_integrator_assert.svh"

module hfai_sva
	import hfai_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            s_tvalid,
	input logic            s_tready,
	input logic            m_tvalid,
	input logic            m_tready,
	input logic [OutW-1:0] m_tdata,
	input logic            m_tuser
);

	`HFAI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`HFAI_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata[LagW+4*AcfW-1:LagW] == '0, "error result carries nonzero correlation")
	`HFAI_ASSERT_NEXT(a_no_instant, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result appeared in the cycle after a request")

endmodule

bind heat_flux_autocorrelation_integrator hfai_sva u_hfai_sva (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

>>> tb/hfai_checker.sv
module hfai_checker
	import hfai_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ScaleW-1:0] cfg_wdata,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [71:0]       s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [OutW-1:0]   m_tdata,
	input  logic              m_tuser,
	output int                fail_count,
	output int                pending,
	output int                lag_results,
	output int                error_results
);

	typedef struct packed {
		logic [15:0] lag;
		logic [47:0] ax;
		logic [47:0] ay;
		logic [47:0] az;
		logic [47:0] mean;
		logic [63:0] cond;
		logic        status;
	} acf_result_t;

	localparam longint Acf48Max = 64'sh00007FFFFFFFFFFF;
	localparam longint Acf48Min = -Acf48Max - 1;
	localparam longint I64Max = 64'sh7FFFFFFFFFFFFFFF;
	localparam longint I64Min = 64'sh8000000000000000;

	logic signed [23:0] flux_x_mem[$];
	logic signed [23:0] flux_y_mem[$];
	logic signed [23:0] flux_z_mem[$];
	int unsigned next_lag;
	longint integral;
	logic [31:0] scale;
	acf_result_t expected_results[$];

	assign pending = expected_results.size();

	function automatic longint sat_sum(longint a, longint b);
		if (b > 0 && a > I64Max - b) return I64Max;
		if (b < 0 && a < I64Min - b) return I64Min;
		return a + b;
	endfunction

	function automatic longint axis_acf(ref logic signed [23:0] s[$], input int unsigned m);
		longint acc;
		longint q;
		int n;
		acc = 0;
		for (n = 0; n + m < s.size(); n++)
			acc = sat_sum(acc, longint'(s[n]) * longint'(s[n+m]));
		q = acc / longint'(s.size() - m);
		if (q > Acf48Max) q = Acf48Max;
		if (q < Acf48Min) q = Acf48Min;
		return q;
	endfunction

	function automatic longint integral_term(longint mean, logic [31:0] sc, int shift);
		logic [63:0] mag;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] q;
		mag = (mean < 0) ? -mean : mean;
		lo = (mag & 64'hFFFFFFFF) * {32'd0, sc};
		hi = (mag >> 32) * {32'd0, sc};
		q = (hi + (lo >> 32)) >> (shift - 32);
		return (mean < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic acf_result_t predict_lag();
		acf_result_t r;
		longint ax;
		longint ay;
		longint az;
		longint mean;
		ax = 0;
		ay = 0;
		az = 0;
		mean = 0;
		r.lag = next_lag[15:0];
		r.status = 1'b1;
		if (next_lag < flux_x_mem.size()) begin
			ax = axis_acf(flux_x_mem, next_lag);
			ay = axis_acf(flux_y_mem, next_lag);
			az = axis_acf(flux_z_mem, next_lag);
			mean = (ax + ay + az) / 3;
			integral = sat_sum(integral,
				integral_term(mean, scale, next_lag == 0 ? 49 : 48));
			next_lag++;
			r.status = 1'b0;
		end
		r.ax = ax[47:0];
		r.ay = ay[47:0];
		r.az = az[47:0];
		r.mean = mean[47:0];
		r.cond = integral;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		acf_result_t got;
		acf_result_t want;
		if (!arst_n) begin
			flux_x_mem.delete();
			flux_y_mem.delete();
			flux_z_mem.delete();
			expected_results.delete();
			next_lag = 0;
			integral = 0;
			scale = ScaleReset;
			fail_count = 0;
			lag_results = 0;
			error_results = 0;
		end else begin
			if (cfg_we)
				scale = cfg_wdata;
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					OP_CLEAR: begin
						flux_x_mem.delete();
						flux_y_mem.delete();
						flux_z_mem.delete();
						next_lag = 0;
						integral = 0;
					end
					OP_LOAD: begin
						if (flux_x_mem.size() < DefMaxSamples) begin
							flux_x_mem.push_back(s_tdata[23:0]);
							flux_y_mem.push_back(s_tdata[47:24]);
							flux_z_mem.push_back(s_tdata[71:48]);
						end
					end
					OP_LAG: expected_results.push_back(predict_lag());
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.lag = m_tdata[15:0];
				got.ax = m_tdata[63:16];
				got.ay = m_tdata[111:64];
				got.az = m_tdata[159:112];
				got.mean = m_tdata[207:160];
				got.cond = m_tdata[271:208];
				got.status = m_tuser;
				if (got.status) error_results++;
				else lag_results++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
		end
	end

endmodule

>>> tb/tb_top.sv
module tb_top;
	import hfai_pkg::*;

	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [ScaleW-1:0] cfg_wdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [71:0]       s_tdata = '0;
	logic [1:0]        s_tuser = OP_CLEAR;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OutW-1:0]   m_tdata;
	logic              m_tuser;
	int                fail_count;
	int                pending;
	int                lag_results;
	int                error_results;
	int                send_idle_pct = 0;
	int                stall_pct = 0;
	int                quiet_cycles = 0;
	int                request_count = 0;

	localparam int QuietLimit = 200000;

	always #4 clk = ~clk;

	heat_flux_autocorrelation_integrator dut (.*);

	hfai_checker chk (.*);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("[heat_flux_autocorrelation_integrator] ERROR");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	function automatic logic [23:0] rand_flux();
		case ($urandom_range(5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'(int'($urandom_range(512)) - 256);
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [71:0] data);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
		request_count++;
	endtask

	task automatic load_flux(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
		send_request(OP_LOAD, {z, y, x});
	endtask

	task automatic drain_and_set_scale(input logic [31:0] value);
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int i;
		int n;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(OP_LAG, '0);
		load_flux(24'h7FFFFF, 24'h800000, 24'h000001);
		load_flux(24'h800000, 24'h7FFFFF, 24'hFFFFFF);
		load_flux(24'h7FFFFF, 24'h7FFFFF, 24'h000000);
		send_request(OP_UNKNOWN, {72{1'b1}});
		for (i = 0; i < 4; i++) send_request(OP_LAG, '0);
		send_request(OP_CLEAR, {72{1'b1}});
		drain_and_set_scale(32'hFFFFFFFF);
		for (i = 0; i < 3; i++) load_flux(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		for (i = 0; i < 3; i++) send_request(OP_LAG, '0);
		drain_and_set_scale(32'd0);
		send_request(OP_CLEAR, '0);
		load_flux(24'h123456, 24'hABCDEF, 24'h0F0F0F);
		send_request(OP_LAG, '0);
		send_request(OP_LAG, '0);

		for (int ph = 0; ph < 4; ph++) begin
			drain_and_set_scale(ph == 0 ? ScaleReset : $urandom());
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 34 : 84) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 34 : 84) : 0;
			for (int s = 0; s < 2; s++) begin
				send_request(OP_CLEAR, 72'($urandom()));
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++) load_flux(rand_flux(), rand_flux(), rand_flux());
				for (i = 0; i < n + $urandom_range(1); i++) begin
					if ($urandom_range(9) == 0)
						send_request(OP_UNKNOWN, 72'({$urandom(), $urandom(), $urandom()}));
					send_request(OP_LAG, 72'({$urandom(), $urandom(), $urandom()}));
				end
			end
		end

		stall_pct = 0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		$display("Sent %0d requests; checked %0d lag results and %0d no-overlap results.",
			request_count, lag_results, error_results);
		$display("Covered clear, load, lag, unknown codes, scale extremes and idle phases.");
		if (fail_count == 0)
			$display("[heat_flux_autocorrelation_integrator] OK");
		else
			$display("[heat_flux_autocorrelation_integrator] ERROR");
		$finish;
	end

endmodule
